@@ hdl/ffca_pkg.sv @@
// Package for the first-fit chunk allocator: status codes, request kinds,
// register indexes, address width and controller states. No dependencies.
package ffca_pkg;

  localparam logic [1:0] StatusDone     = 2'd0;
  localparam logic [1:0] StatusNoFit    = 2'd1;
  localparam logic [1:0] StatusNoEntry  = 2'd2;
  localparam logic [1:0] StatusNotAlloc = 2'd3;

  localparam logic KindAlloc   = 1'b0;
  localparam logic KindRelease = 1'b1;

  localparam logic CfgRegionBase = 1'b0;
  localparam logic CfgRegionSize = 1'b1;

  localparam int unsigned ResetRegionSize = 4096;

  // Width of addresses and lengths held in the chunk table.
  localparam int AddressBits = 32;

  // Controller state, one-hot.
  typedef enum logic [12:0] {
    StIdle     = 13'b0000000000001,
    StClear    = 13'b0000000000010,
    StRead     = 13'b0000000000100,
    StWalk     = 13'b0000000001000,
    StSpareRd  = 13'b0000000010000,
    StSpare    = 13'b0000000100000,
    StSplit    = 13'b0000001000000,
    StSplitCur = 13'b0000010000000,
    StMerge    = 13'b0000100000000,
    StMrgCur   = 13'b0001000000000,
    StMrgNx    = 13'b0010000000000,
    StMrgClr   = 13'b0100000000000,
    StOut      = 13'b1000000000000
  } ffca_state_e;

endpackage

@@ hdl/ffca_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/first_fit_chunk_allocator.sv @@
// First-fit chunk allocator top level; uses ffca_pkg and ffca_ram.
// Each word walks the list entries; an allocate that splits then scans for a
// spare entry and writes the split, and a release then runs a merge pass. The
// table is set up first when stale. N = TABLE_ENTRIES. One word at a time.
// Reset clears control and marks the table stale; the table is rebuilt by a
// pass over all N entries on the first word after reset or a register write.
module first_fit_chunk_allocator #(
  parameter int TABLE_ENTRIES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: alloc_size[31:0], release_address[63:32]; tuser: kind
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  // tdata: block_address[31:0], status[33:32], zero fill [39:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ffca_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int AW = AddressBits;
  localparam int RW = 2 * AW + IW + 3;
  localparam logic [IW:0]   Entries   = (IW + 1)'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LastEntry = IW'(TABLE_ENTRIES - 1);

  ffca_state_e state_q;

  logic [31:0]   base_q, size_q;
  logic          ready_tbl_q;
  logic          kind_q;
  logic [AW-1:0] arg_q;
  logic [IW-1:0] cur_q, nxt_q, spare_q;
  logic [IW:0]   steps_q;
  logic          hit_q;
  logic [31:0]   addr_q;
  logic [1:0]    status_q;
  logic [RW-1:0] cur_rec_q;

  // Descriptor memory: {start, length, link, tail, used, free}.
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  ffca_ram #(.Width(RW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [AW-1:0] r_start, r_len, c_start, c_len;
  logic [IW-1:0] r_link, c_link, r_next, c_next;
  logic          r_tail, r_used, r_free, c_tail, c_used, c_free;
  assign {r_start, r_len, r_link, r_tail, r_used, r_free} = rdata;
  assign {c_start, c_len, c_link, c_tail, c_used, c_free} = cur_rec_q;
  // Out-of-range links read as entry 0.
  assign r_next = ({1'b0, r_link} < Entries) ? r_link : '0;
  assign c_next = ({1'b0, c_link} < Entries) ? c_link : '0;

  // Decisions on the entry just read.
  logic          alloc_fit, rel_hit, walk_end, mrg_join;
  logic [IW:0]   steps_inc;
  logic [AW-1:0] split_start, split_len, join_len;
  assign steps_inc   = steps_q + 1'b1;
  assign alloc_fit   = kind_q == KindAlloc && r_free && r_len >= arg_q;
  assign rel_hit     = kind_q == KindRelease && !r_free && r_start == arg_q;
  assign walk_end    = r_tail || steps_inc >= Entries;
  assign mrg_join    = c_free && r_free && nxt_q != cur_q;
  assign split_start = c_start + arg_q;
  assign split_len   = c_len - arg_q;
  assign join_len    = c_len + r_len;

  logic fire_in;
  assign s_axis_tready = state_q == StIdle && !m_axis_tvalid && !cfg_valid_i;
  assign cfg_ready_o   = state_q == StIdle;
  assign fire_in = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {6'd0, status_q, addr_q};

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = cur_q;
    wdata = rdata;
    raddr = cur_q;
    case (state_q)
      StClear: begin
        we = 1'b1;
        wdata = (cur_q == '0) ? {AW'(base_q), AW'(size_q), {IW{1'b0}}, 3'b111} : '0;
      end
      StWalk: begin
        if (alloc_fit && r_len == arg_q) begin
          we = 1'b1;
          wdata = {r_start, r_len, r_link, r_tail, r_used, 1'b0};
        end else if (rel_hit) begin
          we = 1'b1;
          wdata = {r_start, r_len, r_link, r_tail, r_used, 1'b1};
        end
      end
      StSpareRd: raddr = spare_q;
      StSplit: begin
        we = 1'b1;
        waddr = spare_q;
        wdata = {split_start, split_len, c_link, c_tail, 2'b11};
      end
      StSplitCur: begin
        we = 1'b1;
        wdata = {c_start, arg_q, spare_q, 1'b0, c_used, 1'b0};
      end
      StMrgCur: raddr = r_next;
      StMrgNx: begin
        if (mrg_join) begin
          we = 1'b1;
          wdata = {c_start, join_len, r_link, r_tail, c_used, 1'b1};
        end else begin
          raddr = r_next;
        end
      end
      StMrgClr: begin
        we = 1'b1;
        waddr = nxt_q;
        wdata = '0;
        raddr = c_next;
      end
      default: ;
    endcase
  end

  // Sequencer: set-up, walk, spare search, split, release, merge pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      base_q <= '0;
      size_q <= 32'(ResetRegionSize);
      ready_tbl_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
      status_q <= StatusDone;
      addr_q <= '0;
      kind_q <= KindAlloc;
      arg_q <= '0;
      hit_q <= 1'b0;
      cur_q <= '0;
      nxt_q <= '0;
      spare_q <= '0;
      steps_q <= '0;
      cur_rec_q <= '0;
    end else begin
      if (state_q == StOut) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgRegionBase) base_q <= cfg_data_i;
        else size_q <= cfg_data_i;
        ready_tbl_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (fire_in) begin
            kind_q <= s_axis_tuser;
            arg_q <= s_axis_tuser ? AW'(s_axis_tdata[63:32]) : AW'(s_axis_tdata[31:0]);
            cur_q <= '0;
            steps_q <= '0;
            hit_q <= 1'b0;
            state_q <= ready_tbl_q ? StRead : StClear;
          end
        end
        // Set-up pass: entry 0 covers the region, all others unused.
        StClear: begin
          if (cur_q == LastEntry) begin
            cur_q <= '0;
            ready_tbl_q <= 1'b1;
            state_q <= StRead;
          end else begin
            cur_q <= cur_q + 1'b1;
          end
        end
        StRead: state_q <= StWalk;
        StWalk: begin
          cur_rec_q <= rdata;
          if (alloc_fit) begin
            if (r_len == arg_q) begin
              addr_q <= 32'(r_start);
              status_q <= StatusDone;
              state_q <= StOut;
            end else begin
              spare_q <= '0;
              state_q <= StSpareRd;
            end
          end else if (rel_hit) begin
            hit_q <= 1'b1;
            cur_q <= '0;
            steps_q <= '0;
            state_q <= StMerge;
          end else if (walk_end) begin
            if (kind_q == KindAlloc) begin
              addr_q <= '0;
              status_q <= StatusNoFit;
              state_q <= StOut;
            end else begin
              cur_q <= '0;
              steps_q <= '0;
              state_q <= StMerge;
            end
          end else begin
            cur_q <= r_next;
            steps_q <= steps_inc;
            state_q <= StRead;
          end
        end
        StSpareRd: state_q <= StSpare;
        // Lowest unused entry takes the remainder of the split.
        StSpare: begin
          if (!r_used) begin
            state_q <= StSplit;
          end else if (spare_q == LastEntry) begin
            addr_q <= '0;
            status_q <= StatusNoEntry;
            state_q <= StOut;
          end else begin
            spare_q <= spare_q + 1'b1;
            state_q <= StSpareRd;
          end
        end
        StSplit: state_q <= StSplitCur;
        StSplitCur: begin
          addr_q <= 32'(c_start);
          status_q <= StatusDone;
          state_q <= StOut;
        end
        StMerge: state_q <= StMrgCur;
        // The current record is held in cur_rec_q; the next one comes from memory.
        StMrgCur: begin
          cur_rec_q <= rdata;
          nxt_q <= r_next;
          if (r_tail || steps_q >= Entries) begin
            addr_q <= '0;
            status_q <= hit_q ? StatusDone : StatusNotAlloc;
            state_q <= StOut;
          end else begin
            state_q <= StMrgNx;
          end
        end
        StMrgNx: begin
          steps_q <= steps_inc;
          if (mrg_join) begin
            cur_rec_q <= {c_start, join_len, r_link, r_tail, c_used, 1'b1};
            state_q <= StMrgClr;
          end else begin
            cur_q <= nxt_q;
            cur_rec_q <= rdata;
            nxt_q <= r_next;
            if (walk_end) begin
              addr_q <= '0;
              status_q <= hit_q ? StatusDone : StatusNotAlloc;
              state_q <= StOut;
            end
          end
        end
        // The absorbed entry is cleared while the following one is read.
        StMrgClr: begin
          nxt_q <= c_next;
          if (c_tail || steps_q >= Entries) begin
            addr_q <= '0;
            status_q <= hit_q ? StatusDone : StatusNotAlloc;
            state_q <= StOut;
          end else begin
            state_q <= StMrgNx;
          end
        end
        StOut: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
